// File: rtl/crmd_pkg.sv
// Shared types and constants of the CAN receive message dispatcher.
// No dependencies; imported by every module of the block except crmd_ram.
package crmd_pkg;

    // Request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_FRAME     = 2'd0,
        REQ_POP_SEAT  = 2'd1,
        REQ_POP_GEAR  = 2'd2,
        REQ_POP_ABORT = 2'd3
    } req_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_ABORT_ID     = 2'd0;
    localparam logic [1:0] CFG_GEAR_ID      = 2'd1;
    localparam logic [1:0] CFG_DRIVER_ID    = 2'd2;
    localparam logic [1:0] CFG_PASSENGER_ID = 2'd3;

    localparam int ID_W  = 11;
    localparam int DLC_W = 4;

    // Identifier defaults after reset
    localparam logic [ID_W-1:0] ABORT_ID_RST     = 11'd256;
    localparam logic [ID_W-1:0] GEAR_ID_RST      = 11'd257;
    localparam logic [ID_W-1:0] DRIVER_ID_RST    = 11'd258;
    localparam logic [ID_W-1:0] PASSENGER_ID_RST = 11'd259;

    // Minimum length codes per frame kind
    localparam logic [DLC_W-1:0] ABORT_MIN_DLC     = 4'd3;
    localparam logic [DLC_W-1:0] GEAR_MIN_DLC      = 4'd1;
    localparam logic [DLC_W-1:0] DRIVER_MIN_DLC    = 4'd4;
    localparam logic [DLC_W-1:0] PASSENGER_MIN_DLC = 4'd2;

    // One seat command as stored in the ring
    typedef struct packed {
        logic       seat_side;
        logic [7:0] recline;
        logic [7:0] rotation;
        logic [3:0] rolling_count;
        logic       sum_ok;
    } seat_entry_t;

    localparam int SEAT_ENTRY_W = $bits(seat_entry_t);

    // Abort mailbox contents
    typedef struct packed {
        logic       abort_stop;
        logic [7:0] source_node;
        logic [7:0] reason;
    } abort_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;     // input beat accepted this cycle
        logic fill;     // ring read data is valid, load seat result
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pop_req;     // current input beat is a pop
        logic ring_fetch;  // current input beat is a seat pop on a non-empty ring
    } dp_status_t;

endpackage

// File: rtl/crmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the seat command ring.
module crmd_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/crmd_ctrl.sv
// Sequencing controller of the dispatcher: accept, ring fetch, result send.
// Depends on crmd_pkg for the command and status types.
module crmd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  crmd_pkg::dp_status_t  status,
    output crmd_pkg::dp_cmd_t     cmd
);
    import crmd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_SEND  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Handshake and datapath strobes
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_SEND);
        cmd.take  = in_valid && (state_reg == S_IDLE);
        cmd.fill  = (state_reg == S_FETCH);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.pop_req)
                begin
                    state_next = status.ring_fetch ? S_FETCH : S_SEND;
                end
            end
            S_FETCH:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A frame beat never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !status.pop_req) |=> (state_reg == S_IDLE))
        else $error("frame beat left the idle state");

    // A ring fetch is always followed by the send state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> (state_reg == S_SEND))
        else $error("fetch not followed by send");

    // A stalled result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");

endmodule

// File: rtl/crmd_datapath.sv
// Datapath of the dispatcher: identifier match, mailboxes, ring pointers, results.
// Depends on crmd_pkg and crmd_ram.
module crmd_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [crmd_pkg::ID_W-1:0] cfg_data,
    // input beat
    input  logic [1:0]                req_type,
    input  logic [crmd_pkg::ID_W-1:0] frame_id,
    input  logic                      is_extended,
    input  logic                      is_remote,
    input  logic [crmd_pkg::DLC_W-1:0] length_code,
    input  logic [7:0]                byte0,
    input  logic [7:0]                byte1,
    input  logic [7:0]                byte2,
    input  logic [7:0]                byte3,
    // control
    input  crmd_pkg::dp_cmd_t         cmd,
    output crmd_pkg::dp_status_t      status,
    // result
    output logic                      read_valid,
    output logic                      seat_side,
    output logic [7:0]                recline,
    output logic [7:0]                rotation,
    output logic [3:0]                rolling_count,
    output logic                      sum_ok,
    output logic [1:0]                gear_value,
    output logic                      abort_stop,
    output logic [7:0]                source_node,
    output logic [7:0]                reason,
    output logic                      overflowed
);
    import crmd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    // Configured identifiers
    logic [ID_W-1:0] abort_id_reg;
    logic [ID_W-1:0] gear_id_reg;
    logic [ID_W-1:0] driver_id_reg;
    logic [ID_W-1:0] passenger_id_reg;

    // Ring pointers, flags and mailboxes
    logic [PTR_W-1:0] write_slot_reg;
    logic [PTR_W-1:0] write_slot_next;
    logic [PTR_W-1:0] read_slot_reg;
    logic [PTR_W-1:0] read_slot_next;
    logic             drop_flag_reg;
    logic             drop_flag_next;
    logic             gear_waiting_reg;
    logic             gear_waiting_next;
    logic             abort_waiting_reg;
    logic             abort_waiting_next;
    logic [1:0]       gear_mailbox_reg;
    abort_entry_t     abort_mailbox_reg;

    // Result registers
    logic         read_valid_reg;
    seat_entry_t  seat_res_reg;
    logic [1:0]   gear_value_reg;
    abort_entry_t abort_res_reg;
    logic         overflowed_reg;

    // Decode
    req_t         req;
    logic         std_data;
    logic         hit_abort;
    logic         hit_gear;
    logic         hit_driver;
    logic         hit_passenger;
    logic [7:0]   sum8;
    logic         ring_empty;
    logic         frame_take;
    logic         push;
    logic         pop_seat;
    seat_entry_t  push_entry;
    logic [SEAT_ENTRY_W-1:0] ring_rdata;

    assign req        = req_t'(req_type);
    assign std_data   = !is_extended && !is_remote;
    assign ring_empty = (read_slot_reg == write_slot_reg);
    assign sum8       = byte0 + byte1 + byte2;
    assign frame_take = cmd.take && (req == REQ_FRAME) && std_data;

    // Priority match: the first identifier that matches owns the frame, even if its length is short
    always_comb
    begin
        hit_abort     = 1'b0;
        hit_gear      = 1'b0;
        hit_driver    = 1'b0;
        hit_passenger = 1'b0;
        if (frame_id == abort_id_reg)
        begin
            hit_abort = (length_code >= ABORT_MIN_DLC);
        end
        else if (frame_id == gear_id_reg)
        begin
            hit_gear = (length_code >= GEAR_MIN_DLC);
        end
        else if (frame_id == driver_id_reg)
        begin
            hit_driver = (length_code >= DRIVER_MIN_DLC);
        end
        else if (frame_id == passenger_id_reg)
        begin
            hit_passenger = (length_code >= PASSENGER_MIN_DLC);
        end
    end

    // Build the ring entry for a seat command
    always_comb
    begin
        push_entry.seat_side = hit_passenger;
        push_entry.recline   = byte0;
        push_entry.rotation  = byte1;
        if (hit_passenger)
        begin
            push_entry.rolling_count = 4'd0;
            push_entry.sum_ok        = 1'b1;
        end
        else
        begin
            push_entry.rolling_count = byte2[3:0];
            push_entry.sum_ok        = (byte3 == sum8);
        end
    end

    assign push     = frame_take && (hit_driver || hit_passenger);
    assign pop_seat = cmd.take && (req == REQ_POP_SEAT) && !ring_empty;

    assign status.pop_req    = (req != REQ_FRAME);
    assign status.ring_fetch = (req == REQ_POP_SEAT) && !ring_empty;

    // Pointer and flag updates; drop the oldest entry when the ring is full
    always_comb
    begin
        write_slot_next    = write_slot_reg;
        read_slot_next     = read_slot_reg;
        drop_flag_next     = drop_flag_reg;
        gear_waiting_next  = gear_waiting_reg;
        abort_waiting_next = abort_waiting_reg;
        if (push)
        begin
            write_slot_next = next_slot(write_slot_reg);
            if (next_slot(write_slot_reg) == read_slot_reg)
            begin
                read_slot_next = next_slot(read_slot_reg);
                drop_flag_next = 1'b1;
            end
        end
        if (pop_seat)
        begin
            read_slot_next = next_slot(read_slot_reg);
        end
        if (frame_take && hit_gear)
        begin
            gear_waiting_next = 1'b1;
        end
        if (frame_take && hit_abort)
        begin
            abort_waiting_next = 1'b1;
        end
        if (cmd.take && (req == REQ_POP_GEAR))
        begin
            gear_waiting_next = 1'b0;
        end
        if (cmd.take && (req == REQ_POP_ABORT))
        begin
            abort_waiting_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_id_reg      <= ABORT_ID_RST;
            gear_id_reg       <= GEAR_ID_RST;
            driver_id_reg     <= DRIVER_ID_RST;
            passenger_id_reg  <= PASSENGER_ID_RST;
            write_slot_reg    <= '0;
            read_slot_reg     <= '0;
            drop_flag_reg     <= 1'b0;
            gear_waiting_reg  <= 1'b0;
            abort_waiting_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ABORT_ID:     abort_id_reg     <= cfg_data;
                    CFG_GEAR_ID:      gear_id_reg      <= cfg_data;
                    CFG_DRIVER_ID:    driver_id_reg    <= cfg_data;
                    CFG_PASSENGER_ID: passenger_id_reg <= cfg_data;
                    default:          abort_id_reg     <= abort_id_reg;
                endcase
            end
            write_slot_reg    <= write_slot_next;
            read_slot_reg     <= read_slot_next;
            drop_flag_reg     <= drop_flag_next;
            gear_waiting_reg  <= gear_waiting_next;
            abort_waiting_reg <= abort_waiting_next;
        end
    end

    // Mailbox payloads
    always_ff @(posedge clk)
    begin
        if (frame_take && hit_gear)
        begin
            gear_mailbox_reg <= byte0[1:0];
        end
        if (frame_take && hit_abort)
        begin
            abort_mailbox_reg.abort_stop  <= byte0[0];
            abort_mailbox_reg.source_node <= byte1;
            abort_mailbox_reg.reason      <= byte2;
        end
    end

    // Seat command ring
    crmd_ram #(
        .WIDTH (SEAT_ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (push),
        .waddr (write_slot_reg),
        .wdata (push_entry),
        .re    (pop_seat),
        .raddr (read_slot_reg),
        .rdata (ring_rdata)
    );

    // Result registers: clear on a pop beat, fill seat fields after the fetch
    always_ff @(posedge clk)
    begin
        if (cmd.take && (req != REQ_FRAME))
        begin
            read_valid_reg <= 1'b0;
            seat_res_reg   <= '0;
            gear_value_reg <= 2'd0;
            abort_res_reg  <= '0;
            overflowed_reg <= drop_flag_reg;
            case (req)
                REQ_POP_SEAT:
                begin
                    read_valid_reg <= !ring_empty;
                end
                REQ_POP_GEAR:
                begin
                    if (gear_waiting_reg)
                    begin
                        read_valid_reg <= 1'b1;
                        gear_value_reg <= gear_mailbox_reg;
                    end
                end
                REQ_POP_ABORT:
                begin
                    if (abort_waiting_reg)
                    begin
                        read_valid_reg <= 1'b1;
                        abort_res_reg  <= abort_mailbox_reg;
                    end
                end
                default:
                begin
                    read_valid_reg <= 1'b0;
                end
            endcase
        end
        else if (cmd.fill)
        begin
            seat_res_reg <= seat_entry_t'(ring_rdata);
        end
    end

    assign read_valid    = read_valid_reg;
    assign seat_side     = seat_res_reg.seat_side;
    assign recline       = seat_res_reg.recline;
    assign rotation      = seat_res_reg.rotation;
    assign rolling_count = seat_res_reg.rolling_count;
    assign sum_ok        = seat_res_reg.sum_ok;
    assign gear_value    = gear_value_reg;
    assign abort_stop    = abort_res_reg.abort_stop;
    assign source_node   = abort_res_reg.source_node;
    assign reason        = abort_res_reg.reason;
    assign overflowed    = overflowed_reg;

    // Pointers stay inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (write_slot_reg <= LAST_SLOT) && (read_slot_reg <= LAST_SLOT))
        else $error("ring pointer out of range");

    // Overflow flag is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        drop_flag_reg |=> drop_flag_reg)
        else $error("overflow flag cleared");

    // A pop from a non-empty ring advances the read slot
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_seat |=> (read_slot_reg != $past(read_slot_reg)))
        else $error("seat pop did not advance read slot");

endmodule

// File: rtl/can_rx_message_dispatcher.sv
// Result timing: a gear or abort pop shows its result in the cycle after
// acceptance, a seat pop after the registered ring RAM read and the fetch
// state; frames give none. Frame beats are accepted every cycle outside a pop;
// after a pop the next beat is accepted in the cycle after its result is taken.
// Reset (rst_n low, asynchronous) restores the identifier defaults and
// empties ring and mailboxes at once; ring contents are not cleared.
module can_rx_message_dispatcher #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [crmd_pkg::ID_W-1:0]  cfg_data,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic [crmd_pkg::ID_W-1:0]  frame_id,
    input  logic                       is_extended,
    input  logic                       is_remote,
    input  logic [crmd_pkg::DLC_W-1:0] length_code,
    input  logic [7:0]                 byte0,
    input  logic [7:0]                 byte1,
    input  logic [7:0]                 byte2,
    input  logic [7:0]                 byte3,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       read_valid,
    output logic                       seat_side,
    output logic [7:0]                 recline,
    output logic [7:0]                 rotation,
    output logic [3:0]                 rolling_count,
    output logic                       sum_ok,
    output logic [1:0]                 gear_value,
    output logic                       abort_stop,
    output logic [7:0]                 source_node,
    output logic [7:0]                 reason,
    output logic                       overflowed
);
    import crmd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing
    crmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Matching, storage and result
    crmd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .frame_id      (frame_id),
        .is_extended   (is_extended),
        .is_remote     (is_remote),
        .length_code   (length_code),
        .byte0         (byte0),
        .byte1         (byte1),
        .byte2         (byte2),
        .byte3         (byte3),
        .cmd           (cmd),
        .status        (status),
        .read_valid    (read_valid),
        .seat_side     (seat_side),
        .recline       (recline),
        .rotation      (rotation),
        .rolling_count (rolling_count),
        .sum_ok        (sum_ok),
        .gear_value    (gear_value),
        .abort_stop    (abort_stop),
        .source_node   (source_node),
        .reason        (reason),
        .overflowed    (overflowed)
    );

endmodule
